// ===== src/pxr_pkg.sv =====
// ----------------------------------------------------------------------------
// pxr_pkg
// Types and constants shared by the pixel ripple shifter modules.
// ----------------------------------------------------------------------------
package pxr_pkg;

  localparam int PIX_W   = 24;
  localparam int CNT_W   = 8;
  localparam int MODE_W  = 3;
  localparam int IDX_W   = 4;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 8;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CFG_A_W-1:0] cfg_addr_t;
  typedef logic [CFG_D_W-1:0] cfg_data_t;

  // Item commands.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes.
  localparam cfg_addr_t REG_INTERVAL = 2'd0;
  localparam cfg_addr_t REG_MODE     = 2'd1;

  // Shift modes.
  localparam mode_t MODE_RIGHT    = 3'd0;
  localparam mode_t MODE_LEFT     = 3'd1;
  localparam mode_t MODE_OUT_COLS = 3'd2;
  localparam mode_t MODE_IN_COLS  = 3'd3;
  localparam mode_t MODE_UP       = 3'd4;
  localparam mode_t MODE_DOWN     = 3'd5;
  localparam mode_t MODE_OUT_ROWS = 3'd6;
  localparam mode_t MODE_IN_ROWS  = 3'd7;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_OUT
  } state_t;

  // Command from the controller to the datapath for one accepted request.
  typedef struct packed {
    logic load;   // capture a result this cycle
    logic read;   // result is a pixel read
    logic shift;  // ripple the buffer this cycle
  } dp_cmd_t;

endpackage

// ===== src/pxr_datapath.sv =====
// ----------------------------------------------------------------------------
// pxr_datapath
// Frame buffer registers with per-pixel shift selection, read mux and the
// result registers.
// ----------------------------------------------------------------------------
module pxr_datapath #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  pxr_pkg::dp_cmd_t dp_cmd,
  input  pxr_pkg::mode_t  mode,
  input  pxr_pkg::pix_t   color,
  input  pxr_pkg::idx_t   col,
  input  pxr_pkg::idx_t   row,
  output pxr_pkg::pix_t   pixel,
  output logic            shifted
);
  import pxr_pkg::*;

  localparam int CC = COLUMNS / 2;
  localparam int RC = ROWS / 2;

  pix_t fb      [COLUMNS][ROWS];
  pix_t fb_next [COLUMNS][ROWS];
  pix_t rd_pix;

  for (genvar gx = 0; gx < COLUMNS; gx++) begin : g_col
    for (genvar gy = 0; gy < ROWS; gy++) begin : g_row
      localparam int XL = (gx > 0) ? gx - 1 : gx;
      localparam int XR = (gx < COLUMNS - 1) ? gx + 1 : gx;
      localparam int YL = (gy > 0) ? gy - 1 : gy;
      localparam int YH = (gy < ROWS - 1) ? gy + 1 : gy;

      always_comb begin
        case (mode)
          MODE_RIGHT:    fb_next[gx][gy] = (gx == 0) ? color : fb[XL][gy];
          MODE_LEFT:     fb_next[gx][gy] = (gx == COLUMNS - 1) ? color : fb[XR][gy];
          MODE_OUT_COLS: begin
            if (gx == CC) fb_next[gx][gy] = color;
            else if (gx < CC) fb_next[gx][gy] = fb[XR][gy];
            else fb_next[gx][gy] = fb[XL][gy];
          end
          MODE_IN_COLS: begin
            if (gx == 0 || gx == COLUMNS - 1) fb_next[gx][gy] = color;
            else if (gx < CC) fb_next[gx][gy] = fb[XL][gy];
            else fb_next[gx][gy] = fb[XR][gy];
          end
          MODE_UP:       fb_next[gx][gy] = (gy == ROWS - 1) ? color : fb[gx][YH];
          MODE_DOWN:     fb_next[gx][gy] = (gy == 0) ? color : fb[gx][YL];
          MODE_OUT_ROWS: begin
            // With an odd row count the row just past the centre pair holds.
            if (gy == RC - 1 || gy == RC) fb_next[gx][gy] = color;
            else if (gy <= RC - 2) fb_next[gx][gy] = fb[gx][YH];
            else if (gy >= ROWS - RC + 1) fb_next[gx][gy] = fb[gx][YL];
            else fb_next[gx][gy] = fb[gx][gy];
          end
          default: begin
            if (gy == 0 || gy == ROWS - 1) fb_next[gx][gy] = color;
            else if (gy < RC) fb_next[gx][gy] = fb[gx][YL];
            else fb_next[gx][gy] = fb[gx][YH];
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int x = 0; x < COLUMNS; x++) begin
      for (int y = 0; y < ROWS; y++) begin
        if (rst) begin
          fb[x][y] <= '0;
        end else if (dp_cmd.shift) begin
          fb[x][y] <= fb_next[x][y];
        end
      end
    end
  end

  // Out-of-range coordinates match no pixel and read as zero.
  always_comb begin
    rd_pix = '0;
    for (int x = 0; x < COLUMNS; x++) begin
      for (int y = 0; y < ROWS; y++) begin
        if (int'(col) == x && int'(row) == y) begin
          rd_pix = fb[x][y];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      pixel   <= dp_cmd.read ? rd_pix : '0;
      shifted <= dp_cmd.shift;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    dp_cmd.shift |=> (pixel == '0))
    else $error("ripple result carries a nonzero pixel");

  assert property (@(posedge clk) disable iff (rst)
    dp_cmd.shift |-> dp_cmd.load && !dp_cmd.read)
    else $error("shift issued outside a tick request");

  assert property (@(posedge clk) disable iff (rst)
    dp_cmd.read |-> dp_cmd.load)
    else $error("read issued without a load");

endmodule

// ===== src/pxr_ctrl.sv =====
// ----------------------------------------------------------------------------
// pxr_ctrl
// Handshake state machine, configuration registers and frame counter.
// ----------------------------------------------------------------------------
module pxr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  output logic               out_valid,
  input  logic               out_stall,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  pxr_pkg::cfg_addr_t cfg_index,
  input  pxr_pkg::cfg_data_t cfg_data,
  output pxr_pkg::mode_t     mode,
  output pxr_pkg::dp_cmd_t   dp_cmd
);
  import pxr_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  interval;
  logic [CNT_W-1:0]  frame_count;
  logic [CNT_W-1:0]  count_inc;
  logic              accept;
  logic              ripple;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign count_inc = frame_count + 1'b1;
  assign ripple    = (count_inc >= interval);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_OUT;
      ST_OUT:  if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    case (state)
      ST_IDLE: in_stall  = 1'b0;
      ST_OUT:  out_valid = 1'b1;
      default: in_stall  = 1'b1;
    endcase
  end

  always_comb begin
    dp_cmd.load  = accept;
    dp_cmd.read  = accept && (cmd == CMD_READ);
    dp_cmd.shift = accept && (cmd == CMD_TICK) && ripple;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      interval    <= CNT_W'(1);
      mode        <= MODE_RIGHT;
      frame_count <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INTERVAL: interval <= cfg_data;
          REG_MODE:     mode     <= cfg_data[MODE_W-1:0];
          default:      ;
        endcase
      end
      if (accept && cmd == CMD_TICK) begin
        frame_count <= ripple ? '0 : count_inc;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("new request taken while a result is pending");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

// ===== src/pixel_ripple_shifter.sv =====
// ----------------------------------------------------------------------------
// pixel_ripple_shifter
// RGB frame buffer that ripples one column or row per interval of ticks.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries cmd, color, col and row. A tick
// request (cmd 0) advances the frame counter and, when the counter reaches
// the interval, shifts the whole buffer by one column or row and injects
// color into the freed lines. A read request (cmd 1) returns one pixel.
// Output channel (out_valid/out_stall) returns pixel and shifted; every
// request yields exactly one result, valid in the cycle after acceptance.
// The block holds one request at a time: a request is taken, its result
// is registered on the same edge, and the next request is taken in the
// cycle after the result leaves. A stalled result holds and the input
// stays stalled.
// The configuration port (cfg_valid/cfg_ready) is always ready; index 0 is
// the interval and index 1 the mode. Write it only while idle.
// Reset clears the buffer to black, the counter to zero, interval to one
// and mode to a right shift.
// ----------------------------------------------------------------------------
module pixel_ripple_shifter #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  pxr_pkg::pix_t      color,
  input  pxr_pkg::idx_t      col,
  input  pxr_pkg::idx_t      row,
  output logic               out_valid,
  input  logic               out_stall,
  output pxr_pkg::pix_t      pixel,
  output logic               shifted,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  pxr_pkg::cfg_addr_t cfg_index,
  input  pxr_pkg::cfg_data_t cfg_data
);
  import pxr_pkg::*;

  mode_t   mode;
  dp_cmd_t dp_cmd;

  pxr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .dp_cmd    (dp_cmd)
  );

  pxr_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .dp_cmd  (dp_cmd),
    .mode    (mode),
    .color   (color),
    .col     (col),
    .row     (row),
    .pixel   (pixel),
    .shifted (shifted)
  );

endmodule
